@@ rtl/tmssl_pkg.sv @@
// Package for the thrust mode select / slew limiter block.
// Holds field widths, mode and register codes, and the item structs.
// No dependencies.
package tmssl_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned Q88_W   = 16;
    localparam int unsigned STEP_W  = 15;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TOUT_W  = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;
    localparam int unsigned N_AXES  = 3;

    // Mode codes; values 4 to 7 mean hold
    localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ASCENT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALT   = 3'd3;

    // Item kinds
    localparam logic REQ_CMD    = 1'b0;
    localparam logic REQ_TETHER = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MAX_STEP   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_THRUST = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_THRUST = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_HB_TIMEOUT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HEADING_X  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_HEADING_Y  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_HEADING_Z  = 3'd6;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]       RST_MAX_STEP   = 15'd256;
    localparam logic signed [Q88_W-1:0] RST_MIN_THRUST = 16'sh8000;
    localparam logic signed [Q88_W-1:0] RST_MAX_THRUST = 16'sh7FFF;
    localparam logic [TOUT_W-1:0]       RST_HB_TIMEOUT = 16'd500;

    typedef struct packed {
        logic                     req_type;
        logic [MODE_W-1:0]        mode_req;
        logic signed [Q88_W-1:0]  total_power;
        logic                     pilot_override;
        logic                     tether_critical;
        logic [TIME_W-1:0]        now_ms;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0]        mode_now;
        logic signed [Q88_W-1:0]  thrust_x;
        logic signed [Q88_W-1:0]  thrust_y;
        logic signed [Q88_W-1:0]  thrust_z;
        logic                     heartbeat_lost;
    } t_res;

endpackage

@@ rtl/tmssl_cmd_if.sv @@
// Valid/ready channel carrying one command or tether item.
// Depends on tmssl_pkg.
interface tmssl_cmd_if;
    import tmssl_pkg::*;

    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tmssl_res_if.sv @@
// Valid/ready channel carrying one result item (mode and thrust).
// Depends on tmssl_pkg.
interface tmssl_res_if;
    import tmssl_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/thrust_mode_select_slew_limiter_unit.sv @@
// An input transfer is held in the input register, computed, then held in the result register for o_res.
// Throughput: one item per cycle while the result register frees; input reg, one compute stage, result reg.
// The per-axis Q8.8 multiply, slew and clamp sit in the single compute stage.
// Reset (i_rst_n low, synchronous): pipeline empty, mode manual, heartbeat
// never seen, ramped and held axes zero, config registers at defaults.
// Depends on tmssl_pkg, tmssl_cmd_if, tmssl_res_if.
module thrust_mode_select_slew_limiter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tmssl_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [tmssl_pkg::CDATA_W-1:0] i_cfg_wdata,
    tmssl_cmd_if.sink                     i_cmd,
    tmssl_res_if.source                   o_res
);
    import tmssl_pkg::*;

    // Configuration registers
    logic [STEP_W-1:0]       r_max_step;
    logic signed [Q88_W-1:0] r_min_thrust;
    logic signed [Q88_W-1:0] r_max_thrust;
    logic [TOUT_W-1:0]       r_hb_timeout;
    logic signed [Q88_W-1:0] r_heading [N_AXES];

    // Block state
    logic [MODE_W-1:0]       r_mode;
    logic [TIME_W-1:0]       r_last_hb;
    logic signed [Q88_W-1:0] r_ramped [N_AXES];
    logic signed [Q88_W-1:0] r_held   [N_AXES];

    // Pipeline registers
    logic r_s1_valid;
    t_cmd r_s1;
    logic r_out_valid;
    t_res r_out;

    // Compute stage signals
    logic                    out_adv;
    logic                    s1_fire;
    logic [MODE_W-1:0]       n_mode;
    logic [TIME_W-1:0]       n_last_hb;
    logic [TIME_W-1:0]       hb_age;
    logic                    hb_lost;
    logic signed [Q88_W-1:0] target   [N_AXES];
    logic signed [Q88_W-1:0] n_ramped [N_AXES];
    logic signed [Q88_W-1:0] n_held   [N_AXES];
    t_res                    n_out;

    // Q8.8 product, floor shift by 8, saturate to 16 bits
    function automatic logic signed [Q88_W-1:0] q88_mul(
        input logic signed [Q88_W-1:0] a,
        input logic signed [Q88_W-1:0] b
    );
        logic signed [2*Q88_W-1:0] p;
        logic signed [Q88_W-1:0]   res;
        p = a * b;
        if (!p[2*Q88_W-1] && (|p[2*Q88_W-2:Q88_W+7])) begin
            res = 16'sh7FFF;
        end else if (p[2*Q88_W-1] && !(&p[2*Q88_W-2:Q88_W+7])) begin
            res = 16'sh8000;
        end else begin
            res = p[Q88_W+7:8];
        end
        return res;
    endfunction

    // Move past toward target by at most step
    function automatic logic signed [Q88_W-1:0] slew(
        input logic signed [Q88_W-1:0] past,
        input logic signed [Q88_W-1:0] tgt,
        input logic [STEP_W-1:0]       step
    );
        logic signed [Q88_W:0] d;
        logic signed [Q88_W:0] s;
        logic signed [Q88_W:0] up;
        logic signed [Q88_W:0] dn;
        logic signed [Q88_W-1:0] res;
        d  = {tgt[Q88_W-1], tgt} - {past[Q88_W-1], past};
        s  = {2'b00, step};
        up = {past[Q88_W-1], past} + s;
        dn = {past[Q88_W-1], past} - s;
        if (d > s) begin
            res = up[Q88_W-1:0];
        end else if (d < -s) begin
            res = dn[Q88_W-1:0];
        end else begin
            res = tgt;
        end
        return res;
    endfunction

    // Handshake: result register frees when empty or taken
    assign out_adv     = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && out_adv;
    assign i_cmd.ready = !r_s1_valid || out_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Heartbeat refresh and timeout check
    always_comb begin
        n_last_hb = r_last_hb;
        if (r_s1.mode_req == MODE_MANUAL && r_s1.pilot_override) begin
            n_last_hb = r_s1.now_ms;
        end
        hb_age  = r_s1.now_ms - n_last_hb;
        hb_lost = (n_last_hb != '0) && (hb_age > {{(TIME_W-TOUT_W){1'b0}}, r_hb_timeout});
    end

    // Mode, target selection, slew and clamp for one item
    always_comb begin
        n_mode = r_mode;
        for (int i = 0; i < N_AXES; i++) begin
            target[i]   = r_held[i];
            n_ramped[i] = r_ramped[i];
            n_held[i]   = r_held[i];
        end
        n_out.heartbeat_lost = 1'b0;

        if (r_s1.req_type == REQ_TETHER) begin
            if (r_s1.tether_critical) begin
                n_mode = MODE_HALT;
            end
        end else begin
            n_mode = hb_lost ? MODE_HALT : r_s1.mode_req;
            n_out.heartbeat_lost = hb_lost;
            if (n_mode == MODE_MANUAL && r_s1.pilot_override) begin
                for (int i = 0; i < N_AXES; i++) begin
                    target[i] = q88_mul(r_heading[i], r_s1.total_power);
                end
            end else if (n_mode == MODE_AUTO) begin
                target[0] = '0;
                target[1] = '0;
                target[2] = r_s1.total_power;
            end else if (n_mode == MODE_ASCENT) begin
                target[0] = '0;
                target[1] = '0;
                target[2] = r_max_thrust;
            end else if (n_mode == MODE_HALT) begin
                target[0] = '0;
                target[1] = '0;
                target[2] = '0;
            end
            for (int i = 0; i < N_AXES; i++) begin
                n_ramped[i] = slew(r_ramped[i], target[i], r_max_step);
                if (n_ramped[i] < r_min_thrust) begin
                    n_held[i] = r_min_thrust;
                end else if (n_ramped[i] > r_max_thrust) begin
                    n_held[i] = r_max_thrust;
                end else begin
                    n_held[i] = n_ramped[i];
                end
            end
        end

        n_out.mode_now = n_mode;
        n_out.thrust_x = n_held[0];
        n_out.thrust_y = n_held[1];
        n_out.thrust_z = n_held[2];
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step   <= RST_MAX_STEP;
            r_min_thrust <= RST_MIN_THRUST;
            r_max_thrust <= RST_MAX_THRUST;
            r_hb_timeout <= RST_HB_TIMEOUT;
            for (int i = 0; i < N_AXES; i++) begin
                r_heading[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_STEP:   r_max_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_MIN_THRUST: r_min_thrust <= i_cfg_wdata;
                CFG_MAX_THRUST: r_max_thrust <= i_cfg_wdata;
                CFG_HB_TIMEOUT: r_hb_timeout <= i_cfg_wdata;
                CFG_HEADING_X:  r_heading[0] <= i_cfg_wdata;
                CFG_HEADING_Y:  r_heading[1] <= i_cfg_wdata;
                CFG_HEADING_Z:  r_heading[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Block state updates once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MANUAL;
            r_last_hb <= '0;
            for (int i = 0; i < N_AXES; i++) begin
                r_ramped[i] <= '0;
                r_held[i]   <= '0;
            end
        end else if (s1_fire) begin
            r_mode <= n_mode;
            if (r_s1.req_type == REQ_CMD) begin
                r_last_hb <= n_last_hb;
            end
            for (int i = 0; i < N_AXES; i++) begin
                r_ramped[i] <= n_ramped[i];
                r_held[i]   <= n_held[i];
            end
        end
    end

    // Input and result register valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s1 <= i_cmd.data;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

endmodule

@@ sim/tmssl_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the thrust mode select / slew limiter unit.
// Watches the command, result and config ports, predicts each result, compares.
// Depends on tmssl_pkg, tmssl_cmd_if, tmssl_res_if.
module tmssl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tmssl_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [tmssl_pkg::CDATA_W-1:0] i_cfg_wdata,
    tmssl_cmd_if                          i_cmd,
    tmssl_res_if                          i_res,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    import tmssl_pkg::*;

    // Shadow configuration
    logic [STEP_W-1:0]       step_lim;
    logic signed [Q88_W-1:0] lo_clamp;
    logic signed [Q88_W-1:0] hi_clamp;
    logic [TOUT_W-1:0]       hb_limit;
    logic signed [Q88_W-1:0] heading [N_AXES];

    // Shadow control state
    logic [MODE_W-1:0]       mode_state;
    logic [TIME_W-1:0]       hb_stamp;
    logic signed [Q88_W-1:0] ramp [N_AXES];
    logic signed [Q88_W-1:0] held [N_AXES];

    t_res thrust_reports [$];
    t_res got_res;
    t_res want_res;

    // Advance the shadow state by one command or tether item, return its report
    function automatic t_res thrust_after(input t_cmd c);
        t_res              r;
        logic [TIME_W-1:0] age;
        int                target [N_AXES];
        int                prod;
        int                diff;
        int                lim;
        r.heartbeat_lost = 1'b0;
        if (c.req_type == REQ_TETHER) begin
            if (c.tether_critical) mode_state = MODE_HALT;
        end else begin
            mode_state = c.mode_req;
            if (mode_state == MODE_MANUAL && c.pilot_override) hb_stamp = c.now_ms;
            age = c.now_ms - hb_stamp;
            // stamp of zero means no heartbeat seen yet
            if (hb_stamp != '0 && age > hb_limit) begin
                mode_state       = MODE_HALT;
                r.heartbeat_lost = 1'b1;
            end
            for (int i = 0; i < N_AXES; i++) target[i] = int'(held[i]);
            if (mode_state == MODE_MANUAL && c.pilot_override) begin
                // Q8.8 product, floor shift, saturate
                for (int i = 0; i < N_AXES; i++) begin
                    prod = int'(heading[i]) * int'($signed(c.total_power));
                    prod = prod >>> 8;
                    if (prod > 32767) prod = 32767;
                    if (prod < -32768) prod = -32768;
                    target[i] = prod;
                end
            end else if (mode_state == MODE_AUTO) begin
                target[0] = 0;
                target[1] = 0;
                target[2] = int'($signed(c.total_power));
            end else if (mode_state == MODE_ASCENT) begin
                target[0] = 0;
                target[1] = 0;
                target[2] = int'(hi_clamp);
            end else if (mode_state == MODE_HALT) begin
                target[0] = 0;
                target[1] = 0;
                target[2] = 0;
            end
            // slew against the unclamped ramp, then clamp (min wins over max)
            lim = int'(step_lim);
            for (int i = 0; i < N_AXES; i++) begin
                diff = target[i] - int'(ramp[i]);
                if (diff > lim) ramp[i] = Q88_W'(int'(ramp[i]) + lim);
                else if (diff < -lim) ramp[i] = Q88_W'(int'(ramp[i]) - lim);
                else ramp[i] = Q88_W'(target[i]);
                if (ramp[i] < lo_clamp) held[i] = lo_clamp;
                else if (ramp[i] > hi_clamp) held[i] = hi_clamp;
                else held[i] = ramp[i];
            end
        end
        r.mode_now = mode_state;
        r.thrust_x = held[0];
        r.thrust_y = held[1];
        r.thrust_z = held[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_lim   = RST_MAX_STEP;
            lo_clamp   = RST_MIN_THRUST;
            hi_clamp   = RST_MAX_THRUST;
            hb_limit   = RST_HB_TIMEOUT;
            mode_state = MODE_MANUAL;
            hb_stamp   = '0;
            for (int i = 0; i < N_AXES; i++) begin
                heading[i] = '0;
                ramp[i]    = '0;
                held[i]    = '0;
            end
            thrust_reports.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_STEP:   step_lim = i_cfg_wdata[STEP_W-1:0];
                    CFG_MIN_THRUST: lo_clamp = i_cfg_wdata;
                    CFG_MAX_THRUST: hi_clamp = i_cfg_wdata;
                    CFG_HB_TIMEOUT: hb_limit = i_cfg_wdata;
                    CFG_HEADING_X:  heading[0] = i_cfg_wdata;
                    CFG_HEADING_Y:  heading[1] = i_cfg_wdata;
                    CFG_HEADING_Z:  heading[2] = i_cfg_wdata;
                    default: ;
                endcase
            end
            // result transfer checked before this edge's command is queued
            if (i_res.valid && i_res.ready) begin
                got_res = i_res.data;
                if (thrust_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] result with no command outstanding: mode=%0d", $time,
                                 got_res.mode_now);
                end else begin
                    want_res = thrust_reports.pop_front();
                    if (got_res.mode_now !== want_res.mode_now
                            || got_res.thrust_x !== want_res.thrust_x
                            || got_res.thrust_y !== want_res.thrust_y
                            || got_res.thrust_z !== want_res.thrust_z
                            || got_res.heartbeat_lost !== want_res.heartbeat_lost) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] thrust mismatch: exp mode=%0d x=%0d y=%0d z=%0d ",
                                      "lost=%0b, got mode=%0d x=%0d y=%0d z=%0d lost=%0b"},
                                     $time, want_res.mode_now, $signed(want_res.thrust_x),
                                     $signed(want_res.thrust_y), $signed(want_res.thrust_z),
                                     want_res.heartbeat_lost, got_res.mode_now,
                                     $signed(got_res.thrust_x), $signed(got_res.thrust_y),
                                     $signed(got_res.thrust_z), got_res.heartbeat_lost);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) thrust_reports.push_back(thrust_after(i_cmd.data));
        end
        o_outstanding = thrust_reports.size();
    end

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Top of the thrust mode select / slew limiter testbench: clock, reset, stimulus, verdict.
// Depends on tmssl_pkg, the channel interfaces, the unit and tmssl_checker.
module testbench;
    import tmssl_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_SPARE     = 3'd7;
    localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOLD_TOP = 3'd7;
    localparam int                DRAIN_CYCLES  = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_idx;
    logic [CDATA_W-1:0] i_cfg_wdata;

    logic              calm;
    int                fail_count;
    int                outstanding;
    logic [TIME_W-1:0] clock_ms;
    logic [TOUT_W-1:0] hb_window;

    tmssl_cmd_if cmd_ch ();
    tmssl_res_if res_ch ();

    thrust_mode_select_slew_limiter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch)
    );

    tmssl_checker thrust_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= 29);
    end

    // Present one item and hold it until the transfer; returns on a falling edge
    task automatic send_item(input t_cmd c);
        while (!calm && $urandom_range(99) < 29) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_cmd(input logic [MODE_W-1:0] mode, input logic signed [Q88_W-1:0] power,
                            input logic pilot, input logic [TIME_W-1:0] now);
        t_cmd c;
        c.req_type        = REQ_CMD;
        c.mode_req        = mode;
        c.total_power     = power;
        c.pilot_override  = pilot;
        c.tether_critical = 1'($urandom_range(1));
        c.now_ms          = now;
        send_item(c);
    endtask

    // tether report; every other field is noise
    task automatic push_tether(input logic flag);
        t_cmd c;
        c.req_type        = REQ_TETHER;
        c.mode_req        = MODE_W'($urandom_range(MODE_HOLD_TOP));
        c.total_power     = Q88_W'($urandom);
        c.pilot_override  = 1'($urandom_range(1));
        c.tether_critical = flag;
        c.now_ms          = $urandom;
        send_item(c);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    // write all registers back to back; the spare top bit of the step field is random
    task automatic apply_config(input logic [STEP_W-1:0] step,
                                input logic signed [Q88_W-1:0] lo, input logic signed [Q88_W-1:0] hi,
                                input logic [TOUT_W-1:0] tout,
                                input logic signed [Q88_W-1:0] hx,
                                input logic signed [Q88_W-1:0] hy,
                                input logic signed [Q88_W-1:0] hz);
        cfg_write(CFG_MAX_STEP, {1'($urandom_range(1)), step});
        cfg_write(CFG_MIN_THRUST, lo);
        cfg_write(CFG_MAX_THRUST, hi);
        cfg_write(CFG_HB_TIMEOUT, tout);
        cfg_write(CFG_HEADING_X, hx);
        cfg_write(CFG_HEADING_Y, hy);
        cfg_write(CFG_HEADING_Z, hz);
        i_cfg_we  <= 1'b0;
        hb_window  = tout;
    endtask

    function automatic logic signed [Q88_W-1:0] pick_q88();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3, 4: return Q88_W'($urandom_range(2047) - 1024);
            default: return Q88_W'($urandom);
        endcase
    endfunction

    // One random item: mostly commands on a running clock that keeps the heartbeat alive
    task automatic random_item();
        int                      r;
        logic [MODE_W-1:0]       mode;
        logic                    pilot;
        r = $urandom_range(99);
        if (r < 8) begin
            push_tether(1'($urandom_range(1)));
        end else begin
            r = $urandom_range(99);
            if (r < 35)      mode = MODE_MANUAL;
            else if (r < 55) mode = MODE_AUTO;
            else if (r < 65) mode = MODE_ASCENT;
            else if (r < 75) mode = MODE_HALT;
            else if (r < 92) mode = MODE_HOLD;
            else             mode = MODE_W'($urandom_range(MODE_HOLD + 1, MODE_HOLD_TOP));
            if (mode == MODE_MANUAL) pilot = ($urandom_range(99) < 80);
            else pilot = 1'($urandom_range(1));
            r = $urandom_range(99);
            if (r < 80)      clock_ms += $urandom_range(hb_window / 3 + 1);
            else if (r < 95) clock_ms += $urandom_range(2 * hb_window + 2);
            else             clock_ms = $urandom;
            push_cmd(mode, pick_q88(), pilot, clock_ms);
        end
    endtask

    task automatic random_phase(input int n_items);
        logic [STEP_W-1:0]       step;
        logic signed [Q88_W-1:0] a;
        logic signed [Q88_W-1:0] b;
        logic signed [Q88_W-1:0] lo;
        logic signed [Q88_W-1:0] hi;
        logic [TOUT_W-1:0]       tout;
        case ($urandom_range(4))
            0: step = '0;
            1: step = 15'h7FFF;
            2: step = STEP_W'($urandom_range(1, 64));
            3: step = STEP_W'($urandom_range(65, 2048));
            default: step = STEP_W'($urandom);
        endcase
        a = pick_q88();
        b = pick_q88();
        case ($urandom_range(3))
            0: begin lo = 16'sh8000; hi = 16'sh7FFF; end
            1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
            2: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
            default: begin
                lo = -Q88_W'($urandom_range(4000));
                hi = Q88_W'($urandom_range(4000));
            end
        endcase
        case ($urandom_range(3))
            0: tout = '0;
            1: tout = 16'hFFFF;
            default: tout = TOUT_W'($urandom_range(1, 1000));
        endcase
        apply_config(step, lo, hi, tout, pick_q88(), pick_q88(), pick_q88());
        // sometimes start just short of the clock wrap
        clock_ms = $urandom_range(1) ? (32'hFFFF_FF00 + $urandom_range(255)) : $urandom;
        repeat (n_items) random_item();
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        calm         = 1'b0;
        clock_ms     = '0;
        hb_window    = RST_HB_TIMEOUT;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: ramp from zero, manual without pilot, tether both ways, hold
        push_cmd(MODE_AUTO, 16'sh7FFF, 1'b0, 32'd5);
        push_cmd(MODE_MANUAL, 16'sd1000, 1'b0, 32'd6);
        push_tether(1'b0);
        push_tether(1'b1);
        push_cmd(MODE_HOLD, 16'sd0, 1'b0, 32'd7);
        settle();

        // full-scale headings, largest step, short timeout; spare index must be ignored
        cfg_write(CFG_SPARE, 16'h5A5A);
        apply_config(15'h7FFF, 16'sh8000, 16'sh7FFF, 16'd100,
                     16'sh7FFF, 16'sh8000, 16'sh0100);
        // heartbeat stamped at time zero still counts as never seen
        push_cmd(MODE_MANUAL, 16'sh7FFF, 1'b1, 32'd0);
        push_cmd(MODE_MANUAL, 16'sh8000, 1'b1, 32'd0);
        push_cmd(MODE_AUTO, 16'sd0, 1'b0, 32'd5000);
        // timeout edge: exactly the limit passes, one more trips halt
        push_cmd(MODE_MANUAL, 16'sh0180, 1'b1, 32'd1000);
        push_cmd(MODE_AUTO, -16'sd300, 1'b0, 32'd1100);
        push_cmd(MODE_AUTO, 16'sd300, 1'b0, 32'd1101);
        // heartbeat age across the clock wrap
        push_cmd(MODE_MANUAL, 16'sd1, 1'b1, 32'hFFFF_FFFF);
        push_cmd(MODE_ASCENT, 16'sd0, 1'b0, 32'h0000_0050);
        push_cmd(MODE_HALT, 16'sd0, 1'b0, 32'h0000_0070);
        // upper mode codes hold the last output
        push_cmd(MODE_MANUAL, -16'sd1, 1'b1, 32'd200);
        push_cmd(MODE_HOLD_TOP, 16'sd50, 1'b1, 32'd210);
        push_cmd(MODE_HOLD + 3'd1, 16'sd50, 1'b0, 32'd220);
        settle();

        // frozen ramp, inverted clamp window, zero timeout
        apply_config(15'd0, 16'sd100, -16'sd100, 16'd0, 16'sh0200, -16'sh0080, 16'sh7FFF);
        push_cmd(MODE_AUTO, 16'sd5000, 1'b0, 32'd300);
        push_cmd(MODE_MANUAL, 16'sd500, 1'b1, 32'd400);
        push_cmd(MODE_MANUAL, 16'sd500, 1'b1, 32'd400);
        push_cmd(MODE_AUTO, 16'sd0, 1'b0, 32'd401);
        settle();

        // single-LSB step, widest timeout
        apply_config(15'd1, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0);
        push_cmd(MODE_ASCENT, 16'sd0, 1'b0, 32'd500);
        push_cmd(MODE_AUTO, 16'sh8000, 1'b0, 32'd501);
        settle();

        // random phases; one runs with no idling on either side
        for (int p = 0; p < 6; p++) begin
            calm = (p == 2);
            random_phase(300);
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ thrust_mode_select_slew_limiter_unit.f @@
rtl/tmssl_pkg.sv
rtl/tmssl_cmd_if.sv
rtl/tmssl_res_if.sv
rtl/thrust_mode_select_slew_limiter_unit.sv
sim/tmssl_checker.sv
sim/testbench.sv
